// ===== sv/kfd_pkg.sv =====
// shared types and constants for the keyframe displacement test
`default_nettype none

package kfd_pkg;

  // field widths
  localparam int unsigned CoordW = 17;
  localparam int unsigned CntW   = 13;
  localparam int unsigned SumW   = 30;
  localparam int unsigned MmdW   = 16;
  localparam int unsigned CfgDW  = 16;
  localparam int unsigned CfgIW  = 2;

  // square root unit: radicand padded to an even width, one root bit per step
  localparam int unsigned SqW      = 2 * CoordW;
  localparam int unsigned RadW     = 36;
  localparam int unsigned RootW    = RadW / 2;
  localparam int unsigned RemW     = RootW + 2;
  localparam int unsigned StepW    = 5;
  localparam int unsigned SqrtLast = RootW - 1;

  // match count saturation
  localparam int unsigned MaxMatches = 4096;
  localparam int unsigned CntFieldMax = (1 << CntW) - 1;
  localparam int unsigned CntCap =
    (MaxMatches < CntFieldMax) ? MaxMatches : CntFieldMax;

  // sum saturation
  localparam logic [SumW-1:0] SumMax = '1;

  // decision product widths
  localparam int unsigned MwW   = MmdW + CntW;
  localparam int unsigned ProdW = MwW + CntW;
  localparam int unsigned LhsShift = 12;

  // configuration register indexes
  typedef enum logic [CfgIW-1:0] {
    CFG_MIN_MATCHES       = 2'd0,
    CFG_MIN_MEAN_DISTANCE = 2'd1,
    CFG_IMAGE_WIDTH       = 2'd2
  } cfg_idx_e;

  localparam logic [CntW-1:0] WidthReset = 13'd640;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ADD,
    ST_ROOT,
    ST_PROD,
    ST_DECIDE
  } kfd_state_e;

  // status of the serial square root unit
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

`default_nettype wire

// ===== sv/keyframe_displacement_test_core.sv =====
// keyframe selection by mean keypoint displacement, top level
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   ref_x ref_y cur_x cur_y valid_req has_reference last
//   out      output     out_valid/out_stall is_keyframe match_count distance_sum
//   cfg      input      cfg_valid/cfg_ready cfg_index_i cfg_data_i
//
// between the transfer of a match and the next input transfer the core takes
// the differences, squares, adds, runs the serial square root unit (one root
// bit per cycle) and accumulates. an item without a match that is not last
// leaves the input open. the last item of a frame then adds the threshold
// product and the compare, plus any wait for the output register.
// reset clears the frame sum and count and loads the register defaults.
// the output register holds a result under stall while the next frame runs.
`default_nettype none

module keyframe_displacement_test_core
  import kfd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input items
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CoordW-1:0] ref_x_i,
  input  wire logic [CoordW-1:0] ref_y_i,
  input  wire logic [CoordW-1:0] cur_x_i,
  input  wire logic [CoordW-1:0] cur_y_i,
  input  wire logic              valid_req_i,
  input  wire logic              has_reference_i,
  input  wire logic              last_i,
  // results
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   is_keyframe_o,
  output logic      [CntW-1:0]   match_count_o,
  output logic      [SumW-1:0]   distance_sum_o,
  // configuration writes
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CfgIW-1:0]  cfg_index_i,
  input  wire logic [CfgDW-1:0]  cfg_data_i
);

  kfd_state_e state_q, state_d;

  // configuration registers
  logic [CntW-1:0] min_matches_q;
  logic [MmdW-1:0] min_mean_q;
  logic [CntW-1:0] width_q;
  logic [MwW-1:0]  mw_q;

  // item registers
  logic [CoordW-1:0] dx_q, dy_q;
  logic              has_ref_q, last_q;
  logic [SqW-1:0]    sqx_q, sqy_q;

  // frame accumulators
  logic [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0] count_q, count_d;
  logic [ProdW-1:0] prod_q;

  // output register
  logic            out_valid_q, out_valid_d;
  logic            key_q;
  logic [CntW-1:0] cnt_out_q;
  logic [SumW-1:0] sum_out_q;

  logic             in_xfer;
  logic             out_free;
  logic             load_out;
  logic             sq_start;
  logic [RadW-1:0]  radicand;
  logic [RootW-1:0] root;
  sqrt_stat_t       sq_stat;
  logic [SumW:0]    sum_add;
  logic [ProdW-1:0] lhs;
  logic             key;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_q || !out_stall;

  // configuration port, always open
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_matches_q <= '0;
      min_mean_q    <= '0;
      width_q       <= WidthReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_MATCHES:       min_matches_q <= cfg_data_i[CntW-1:0];
        CFG_MIN_MEAN_DISTANCE: min_mean_q    <= cfg_data_i[MmdW-1:0];
        CFG_IMAGE_WIDTH:       width_q       <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // threshold times width, refreshed every cycle
  always_ff @(posedge clk_i) begin
    mw_q <= {{CntW{1'b0}}, min_mean_q} * {{MmdW{1'b0}}, width_q};
  end

  // coordinate differences on transfer, squares in the following cycle
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      dx_q      <= (ref_x_i >= cur_x_i) ? ref_x_i - cur_x_i : cur_x_i - ref_x_i;
      dy_q      <= (ref_y_i >= cur_y_i) ? ref_y_i - cur_y_i : cur_y_i - ref_y_i;
      has_ref_q <= has_reference_i;
      last_q    <= last_i;
    end
    if (state_q == ST_SQUARE) begin
      sqx_q <= {{CoordW{1'b0}}, dx_q} * {{CoordW{1'b0}}, dx_q};
      sqy_q <= {{CoordW{1'b0}}, dy_q} * {{CoordW{1'b0}}, dy_q};
    end
  end

  // serial square root
  assign sq_start = (state_q == ST_ADD);
  assign radicand = RadW'({1'b0, sqx_q} + {1'b0, sqy_q});

  kfd_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (radicand),
    .root_o     (root),
    .stat_o     (sq_stat)
  );

  // saturating sum and the keyframe test
  assign sum_add = {1'b0, sum_q} + {{(SumW+1-RootW){1'b0}}, root};
  assign lhs     = {sum_q, {LhsShift{1'b0}}};
  assign key     = has_ref_q && (count_q != '0) && (count_q >= min_matches_q) &&
                   (lhs > prod_q);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PROD) begin
      prod_q <= {{CntW{1'b0}}, mw_q} * {{MwW{1'b0}}, count_q};
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall;
    load_out    = 1'b0;
    in_stall    = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (valid_req_i) begin
            state_d = ST_SQUARE;
          end else if (last_i) begin
            state_d = ST_PROD;
          end
        end
      end
      ST_SQUARE: state_d = ST_ADD;
      ST_ADD:    state_d = ST_ROOT;
      ST_ROOT: begin
        if (sq_stat.done) begin
          sum_d = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
          if (count_q < CntW'(CntCap)) begin
            count_d = count_q + 1'b1;
          end
          state_d = last_q ? ST_PROD : ST_IDLE;
        end
      end
      ST_PROD: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          sum_d       = '0;
          count_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      key_q     <= key;
      cnt_out_q <= count_q;
      sum_out_q <= sum_q;
    end
  end

  assign out_valid      = out_valid_q;
  assign is_keyframe_o  = key_q;
  assign match_count_o  = cnt_out_q;
  assign distance_sum_o = sum_out_q;

  // checks
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CntCap))
    else $error("match count above cap");

  a_root_in_root_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_stat.done |-> state_q == ST_ROOT)
    else $error("root finished outside root state");

  a_stall_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_stat.busy |-> in_stall)
    else $error("input open while root unit busy");

  a_frame_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> sum_q == '0 && count_q == '0 && out_valid_q)
    else $error("frame not cleared after result");

endmodule

`default_nettype wire

// ===== sv/kfd_sqrt.sv =====
// serial integer square root, two radicand bits shifted in per cycle
`default_nettype none

module kfd_sqrt
  import kfd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [RadW-1:0]  radicand_i,
  output logic      [RootW-1:0] root_o,
  output sqrt_stat_t            stat_o
);

  logic [RadW-1:0]  rad_q, rad_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [RemW+1:0]  rem_sh;
  logic [RemW+1:0]  trial;
  logic             fits;

  // one restoring step: bring down two bits, try appending a one
  always_comb begin
    rem_sh = {rem_q, rad_q[RadW-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    fits   = (rem_sh >= trial);

    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      step_d = StepW'(SqrtLast);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = {rad_q[RadW-3:0], 2'b00};
      rem_d  = fits ? RemW'(rem_sh - trial) : RemW'(rem_sh);
      root_d = {root_q[RootW-2:0], fits};
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o      = root_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

// ===== tb/kfd_frame_checker.sv =====
`timescale 1ns / 1ps
// frame verdict checker: tracks transfers, predicts keyframe decisions, compares results
module kfd_frame_checker
  import kfd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input channel
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [CoordW-1:0] ref_x_i,
  input  wire logic [CoordW-1:0] ref_y_i,
  input  wire logic [CoordW-1:0] cur_x_i,
  input  wire logic [CoordW-1:0] cur_y_i,
  input  wire logic              valid_req_i,
  input  wire logic              has_reference_i,
  input  wire logic              last_i,
  // result channel
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic              is_keyframe_i,
  input  wire logic [CntW-1:0]   match_count_i,
  input  wire logic [SumW-1:0]   distance_sum_i,
  // register writes
  input  wire logic              cfg_valid,
  input  wire logic              cfg_ready,
  input  wire logic [CfgIW-1:0]  cfg_index_i,
  input  wire logic [CfgDW-1:0]  cfg_data_i,
  // status toward the testbench top
  output int                     fail_count_o,
  output int                     open_frames_o
);

  typedef struct packed {
    logic            keyframe;
    logic [CntW-1:0] count;
    logic [SumW-1:0] sum;
  } frame_verdict_t;

  frame_verdict_t  frame_verdicts[$];
  logic [SumW-1:0] sum_acc;
  logic [CntW-1:0] count_acc;
  logic [CntW-1:0] min_matches_q;
  logic [MmdW-1:0] min_mean_q;
  logic [CntW-1:0] width_q;
  int              fails = 0;

  // floored square root, one root bit per pass from the top
  function automatic logic [RootW-1:0] floor_root(input logic [RadW-1:0] rad);
    logic [RootW-1:0] root;
    logic [RootW-1:0] probe;
    root = '0;
    for (int b = RootW - 1; b >= 0; b--) begin
      probe = root | (RootW'(1) << b);
      if (64'(probe) * 64'(probe) <= 64'(rad)) root = probe;
    end
    return root;
  endfunction

  function automatic logic [CoordW-1:0] coord_gap(input logic [CoordW-1:0] a,
                                                  input logic [CoordW-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // euclidean displacement of one pair, q14.4 pixels
  function automatic logic [RootW-1:0] pair_distance(input logic [CoordW-1:0] rx,
                                                     input logic [CoordW-1:0] ry,
                                                     input logic [CoordW-1:0] cx,
                                                     input logic [CoordW-1:0] cy);
    logic [RadW-1:0] gx;
    logic [RadW-1:0] gy;
    gx = RadW'(coord_gap(rx, cx));
    gy = RadW'(coord_gap(ry, cy));
    return floor_root(gx * gx + gy * gy);
  endfunction

  // division-free mean test against the threshold scaled by width and count
  function automatic logic keyframe_call(input logic href, input logic [SumW-1:0] s,
                                         input logic [CntW-1:0] n);
    longint unsigned scaled_sum;
    longint unsigned bar;
    if (!href || n == '0 || n < min_matches_q) return 1'b0;
    scaled_sum = 64'(s) << LhsShift;
    bar = 64'(min_mean_q) * 64'(width_q) * 64'(n);
    return scaled_sum > bar;
  endfunction

  always @(posedge clk_i) begin : track
    frame_verdict_t   seen;
    frame_verdict_t   want;
    logic [RootW-1:0] gap_len;
    longint unsigned  grown;
    if (!rst_ni) begin
      sum_acc       = '0;
      count_acc     = '0;
      min_matches_q = '0;
      min_mean_q    = '0;
      width_q       = WidthReset;
      frame_verdicts.delete();
    end else begin
      // result transfer against the oldest open frame
      if (out_valid && !out_stall) begin
        seen = '{is_keyframe_i, match_count_i, distance_sum_i};
        if (frame_verdicts.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result: key %0b count %0d sum %0d",
                     $time, seen.keyframe, seen.count, seen.sum);
        end else begin
          want = frame_verdicts.pop_front();
          if (seen.keyframe !== want.keyframe || seen.count !== want.count ||
              seen.sum !== want.sum) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch: want key %0b cnt %0d sum %0d, got key %0b cnt %0d sum %0d",
                       $time, want.keyframe, want.count, want.sum,
                       seen.keyframe, seen.count, seen.sum);
          end
        end
      end
      // register write transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_i)
          CFG_MIN_MATCHES:       min_matches_q = cfg_data_i[CntW-1:0];
          CFG_MIN_MEAN_DISTANCE: min_mean_q    = cfg_data_i[MmdW-1:0];
          CFG_IMAGE_WIDTH:       width_q       = cfg_data_i[CntW-1:0];
          default: ;
        endcase
      end
      // input transfer: accumulate the match, close the frame on its last item
      if (in_valid && !in_stall) begin
        if (valid_req_i) begin
          gap_len = pair_distance(ref_x_i, ref_y_i, cur_x_i, cur_y_i);
          grown   = 64'(sum_acc) + 64'(gap_len);
          sum_acc = (grown > 64'(SumMax)) ? SumMax : grown[SumW-1:0];
          if (count_acc < CntW'(CntCap)) count_acc = count_acc + 1'b1;
        end
        if (last_i) begin
          frame_verdicts.push_back(frame_verdict_t'{
            keyframe_call(has_reference_i, sum_acc, count_acc), count_acc, sum_acc});
          sum_acc   = '0;
          count_acc = '0;
        end
      end
    end
    fail_count_o  = fails;
    open_frames_o = frame_verdicts.size();
  end

endmodule

// ===== tb/tb_keyframe_displacement_test_core.sv =====
`timescale 1ns / 1ps
// testbench top: drives frames and register writes into the keyframe displacement core
module tb_keyframe_displacement_test_core;
  import kfd_pkg::*;

  localparam logic [CoordW-1:0] CoordTop = '1;
  localparam int unsigned CoordMax    = (1 << CoordW) - 1;
  localparam int          DrainCycles = 32;
  localparam int          HoldCycles  = 400;
  localparam int          LongPairs   = 20;
  localparam int          SegItems    = 52;

  typedef struct packed {
    logic [CoordW-1:0] rx, ry, cx, cy;
    logic              vreq, href, lst;
  } pair_item_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [CoordW-1:0] ref_x         = '0;
  logic [CoordW-1:0] ref_y         = '0;
  logic [CoordW-1:0] cur_x         = '0;
  logic [CoordW-1:0] cur_y         = '0;
  logic              valid_req     = 1'b0;
  logic              has_reference = 1'b0;
  logic              frame_last    = 1'b0;
  logic              out_valid;
  logic              out_stall;
  logic              is_keyframe;
  logic [CntW-1:0]   match_count;
  logic [SumW-1:0]   distance_sum;
  logic              cfg_valid     = 1'b0;
  logic              cfg_ready;
  logic [CfgIW-1:0]  cfg_index     = '0;
  logic [CfgDW-1:0]  cfg_data      = '0;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  bit   hold_req       = 1'b0;
  logic hold_on        = 1'b0;
  int   fail_count;
  int   open_frames;

  keyframe_displacement_test_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .ref_x_i         (ref_x),
    .ref_y_i         (ref_y),
    .cur_x_i         (cur_x),
    .cur_y_i         (cur_y),
    .valid_req_i     (valid_req),
    .has_reference_i (has_reference),
    .last_i          (frame_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .is_keyframe_o   (is_keyframe),
    .match_count_o   (match_count),
    .distance_sum_o  (distance_sum),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  kfd_frame_checker u_frame_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .ref_x_i         (ref_x),
    .ref_y_i         (ref_y),
    .cur_x_i         (cur_x),
    .cur_y_i         (cur_y),
    .valid_req_i     (valid_req),
    .has_reference_i (has_reference),
    .last_i          (frame_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .is_keyframe_i   (is_keyframe),
    .match_count_i   (match_count),
    .distance_sum_i  (distance_sum),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .open_frames_o   (open_frames)
  );

  always #5 clk_i = ~clk_i;

  // result side back-pressure: random stall plus the long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // long hold-off, counted here while the sender keeps offering frames
  always begin : long_hold
    wait (hold_req);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on <= 1'b0;
    wait (!hold_req);
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // one input transfer, idling before it at the sender's rate
  task automatic push_item(input pair_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    ref_x         <= it.rx;
    ref_y         <= it.ry;
    cur_x         <= it.cx;
    cur_y         <= it.cy;
    valid_req     <= it.vreq;
    has_reference <= it.href;
    frame_last    <= it.lst;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // stop sending and let every open frame deliver its result
  task automatic drain_frames();
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (open_frames == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [CfgDW-1:0] mm, input logic [CfgDW-1:0] mmd,
                          input logic [CfgDW-1:0] w);
    write_reg(CFG_MIN_MATCHES, mm);
    write_reg(CFG_MIN_MEAN_DISTANCE, mmd);
    write_reg(CFG_IMAGE_WIDTH, w);
    cfg_valid <= 1'b0;
  endtask

  // move a coordinate by step, staying inside the field range
  function automatic logic [CoordW-1:0] nudge(input logic [CoordW-1:0] base,
                                              input logic [CoordW-1:0] step);
    if (int'(base) + int'(step) <= CoordMax) return base + step;
    if (base >= step) return base - step;
    return CoordW'($urandom_range(CoordMax));
  endfunction

  // random pair whose displacement stays below 2^scale per axis
  function automatic pair_item_t random_pair(input int unsigned scale);
    pair_item_t it;
    it      = '0;
    it.rx   = CoordW'($urandom_range(CoordMax));
    it.ry   = CoordW'($urandom_range(CoordMax));
    it.cx   = nudge(it.rx, CoordW'($urandom_range((1 << scale) - 1)));
    it.cy   = nudge(it.ry, CoordW'($urandom_range((1 << scale) - 1)));
    it.vreq = 1'b1;
    it.href = 1'(($urandom_range(1)));
    return it;
  endfunction

  // random frames until about budget items that carry a match or close a frame
  task automatic random_frames(input int budget);
    pair_item_t  it;
    int          counted;
    int          n_pairs;
    int unsigned scale;
    logic        frame_ref;
    counted = 0;
    while (counted < budget) begin
      scale     = ($urandom_range(3) == 0) ? $urandom_range(17) : $urandom_range(4, 10);
      frame_ref = ($urandom_range(9) != 0);
      if ($urandom_range(99) < 6) n_pairs = 0;
      else if ($urandom_range(1) == 1) n_pairs = $urandom_range(1, 3);
      else n_pairs = $urandom_range(4, 12);
      for (int i = 0; i < ((n_pairs == 0) ? 1 : n_pairs); i++) begin
        // ignored item in the middle of a frame
        if ($urandom_range(9) == 0) begin
          it      = random_pair(17);
          it.vreq = 1'b0;
          push_item(it);
        end
        it = random_pair(scale);
        if (n_pairs == 0 || i == n_pairs - 1) begin
          it.lst  = 1'b1;
          it.href = frame_ref;
          it.vreq = (n_pairs != 0) && ($urandom_range(9) != 0);
        end
        push_item(it);
        counted++;
      end
    end
  endtask

  initial begin : stimulus
    pair_item_t       it;
    logic [CfgDW-1:0] mm;
    logic [CfgDW-1:0] mmd;
    logic [CfgDW-1:0] w;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed frames at the reset register values
    send_idle_pct  = 27;
    recv_stall_pct = 65;
    push_item(pair_item_t'{17'd0, 17'd0, CoordTop, CoordTop, 1'b1, 1'b0, 1'b0});
    push_item(pair_item_t'{CoordTop, CoordTop, 17'd0, 17'd0, 1'b1, 1'b0, 1'b0});
    push_item(pair_item_t'{CoordTop, 17'd0, 17'd0, CoordTop, 1'b1, 1'b0, 1'b0});
    push_item(pair_item_t'{17'd5, 17'd5, 17'd5, 17'd5, 1'b1, 1'b1, 1'b1});
    // empty frame
    push_item(pair_item_t'{17'd0, 17'd0, 17'd0, 17'd0, 1'b0, 1'b1, 1'b1});
    // no reference keyframe
    push_item(pair_item_t'{17'd0, 17'd0, 17'd16, 17'd0, 1'b1, 1'b1, 1'b0});
    push_item(pair_item_t'{17'd0, 17'd0, 17'd0, 17'd16, 1'b1, 1'b0, 1'b1});
    // zero displacement never beats a zero threshold
    push_item(pair_item_t'{CoordTop, CoordTop, CoordTop, CoordTop, 1'b1, 1'b1, 1'b1});
    // ignored item mid frame, then a last item without a match
    push_item(pair_item_t'{17'd100, 17'd200, 17'd300, 17'd50, 1'b1, 1'b0, 1'b0});
    push_item(pair_item_t'{CoordTop, 17'd0, 17'd0, CoordTop, 1'b0, 1'b1, 1'b0});
    push_item(pair_item_t'{17'd7, 17'd9, 17'd1000, 17'd3, 1'b1, 1'b0, 1'b0});
    push_item(pair_item_t'{17'd1, 17'd2, 17'd3, 17'd4, 1'b0, 1'b1, 1'b1});

    // too few matches, then just enough
    drain_frames();
    set_regs(16'd3, 16'd0, 16'd640);
    push_item(pair_item_t'{17'd10, 17'd10, 17'd50, 17'd90, 1'b1, 1'b1, 1'b0});
    push_item(pair_item_t'{17'd10, 17'd10, 17'd90, 17'd50, 1'b1, 1'b1, 1'b1});
    push_item(pair_item_t'{17'd10, 17'd10, 17'd50, 17'd90, 1'b1, 1'b1, 1'b0});
    push_item(pair_item_t'{17'd10, 17'd10, 17'd90, 17'd50, 1'b1, 1'b1, 1'b0});
    push_item(pair_item_t'{17'd20, 17'd10, 17'd10, 17'd10, 1'b1, 1'b1, 1'b1});

    // zero width with the largest threshold, then an empty frame
    drain_frames();
    set_regs(16'd0, 16'hFFFF, 16'd0);
    push_item(pair_item_t'{17'd100, 17'd100, 17'd101, 17'd100, 1'b1, 1'b1, 1'b1});
    push_item(pair_item_t'{17'd0, 17'd0, 17'd0, 17'd0, 1'b0, 1'b1, 1'b1});

    // random segments, each behind its own register setting
    for (int seg = 0; seg < 9; seg++) begin
      drain_frames();
      case (seg / 3)
        0: begin send_idle_pct = 27; recv_stall_pct = 65; end
        1: begin send_idle_pct = 65; recv_stall_pct = 27; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      mm  = CfgDW'($urandom_range(12));
      mmd = CfgDW'($urandom_range(16'hFFFF) >> $urandom_range(15));
      w   = CfgDW'($urandom_range(1, 8191));
      case (seg)
        0: begin mm = 16'd0; w = 16'd640; end
        1: begin mm = 16'd2; mmd = 16'hFFFF; w = 16'd1; end
        2: begin mm = 16'd8191; mmd = 16'd0; w = 16'd8191; end
        3: begin mm = 16'd1; w = 16'd8191; end
        4: begin mm = 16'd4096; mmd = 16'd0; end
        5: w = 16'd0;
        7: begin mm = 16'd3; mmd = 16'hFFFF; w = 16'd8191; end
        default: ;
      endcase
      set_regs(mm, mmd, w);
      random_frames(SegItems);
    end

    // hold the result side off while short frames keep coming
    drain_frames();
    set_regs(16'd0, 16'd100, 16'd640);
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) begin
      it      = random_pair(6);
      it.lst  = 1'b1;
      it.href = 1'b1;
      push_item(it);
    end
    hold_req = 1'b0;

    // one longer frame of the largest displacements against the top threshold
    drain_frames();
    set_regs(16'd16, 16'hFFFF, 16'd8191);
    for (int i = 0; i < LongPairs; i++)
      push_item(pair_item_t'{17'd0, 17'd0, CoordTop, CoordTop, 1'b1, 1'b1,
                             (i == LongPairs - 1)});

    drain_frames();
    if (fail_count == 0 && open_frames == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/kfd_pkg.sv
sv/kfd_sqrt.sv
sv/keyframe_displacement_test_core.sv
tb/kfd_frame_checker.sv
tb/tb_keyframe_displacement_test_core.sv
